@@ src/fiic_pkg.sv @@
// ----------------------------------------------------------------------------
// fiic_pkg
// Shared types and constants for the feedforward/feedback comb filter.
// ----------------------------------------------------------------------------
package fiic_pkg;

    localparam int DEFAULT_DELAY_DEPTH = 4096;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int GAIN_BITS     = 16;
    localparam int FRAC_BITS     = 15;
    localparam int DELAY_BITS    = 12;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic {
        MODE_FIR = 1'b0,
        MODE_IIR = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE  = 2'd0,
        CFG_GAIN  = 2'd1,
        CFG_DELAY = 2'd2
    } t_cfg_idx;

endpackage

@@ src/fiic_delay_mem.sv @@
// ----------------------------------------------------------------------------
// fiic_delay_mem
// Circular delay store: one write and one registered read per cycle.
// Writes arrive in address order from zero; a fill count makes entries not
// yet written read as zero.
// ----------------------------------------------------------------------------
module fiic_delay_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_hit;
    logic [FW-1:0]    r_fill;
    logic             fill_full;

    assign fill_full = (r_fill == FW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en && !fill_full) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= (FW'(i_rd_addr) < r_fill);
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

    a_write_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en && !fill_full |-> i_wr_addr == AW'(r_fill))
        else $error("delay store written out of order while filling");

    a_fill_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en && !fill_full |=> r_fill == FW'($past(r_fill) + 1'b1))
        else $error("fill count missed a write");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");

endmodule

@@ src/fir_iir_comb_filter_unit.sv @@
// ----------------------------------------------------------------------------
// fir_iir_comb_filter_unit
// Comb filter, FIR (y = x + g*x[n-D]) or IIR (y = x + g*y[n-D]).
// The input request is registered into stage B, then into the output register, which drives output valid.
// Throughput: one sample per cycle while the output is not stalled and no register write is settling;
// one memory read, one multiply-add and one write-back per sample, with forwarding from the write-back port.
// s_axis_tready drops after any register write until the delay modulo settles.
// Reset: synchronous; no clearing pass, unwritten store entries read as zero.
// ----------------------------------------------------------------------------
module fir_iir_comb_filter_unit
    import fiic_pkg::*;
#(
    parameter int DELAY_DEPTH = DEFAULT_DELAY_DEPTH,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]               i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]              i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_in
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_W  = GAIN_BITS + SAMPLE_BITS;
    localparam int SUM_W   = SAMPLE_BITS + 2;
    localparam int DLY_SH  = DELAY_BITS + $clog2(DELAY_DEPTH);
    localparam longint unsigned DLY_RECIP =
        ((64'd1 << DLY_SH) + longint'(DELAY_DEPTH) - 1) / longint'(DELAY_DEPTH);
    localparam int RECIP_W = DELAY_BITS + 2;
    localparam int DPROD_W = DELAY_BITS + RECIP_W;

    // configuration
    t_mode                          r_mode;
    logic signed [GAIN_BITS-1:0]    r_gain;
    logic [DELAY_BITS-1:0]          r_delay;
    logic [DELAY_BITS-1:0]          r_dl_q;
    logic [AW-1:0]                  r_dl_mod;
    logic [1:0]                     r_cfg_wait;

    logic [DPROD_W-1:0]             dl_prod;
    logic [DELAY_BITS-1:0]          dl_quo;
    logic [DELAY_BITS-1:0]          dl_qd;
    logic [DELAY_BITS-1:0]          dl_rem;

    // pipeline
    logic [AW-1:0]                  r_wp;
    logic                           r_b_valid;
    logic signed [SAMPLE_BITS-1:0]  r_b_x;
    logic                           r_b_last;
    logic [AW-1:0]                  r_b_wp;
    logic                           r_b_self;
    logic                           r_b_fwd;
    logic signed [SAMPLE_BITS-1:0]  r_b_fwd_data;
    logic                           r_o_valid;
    logic [SAMPLE_BITS-1:0]         r_o_sample;
    logic                           r_o_last;

    logic                           a_fire;
    logic                           b_fire;
    logic [AW-1:0]                  rd_addr;
    logic [AW-1:0]                  n_wp;
    logic                           a_self;
    logic [SAMPLE_BITS-1:0]         mem_rd_data;
    logic signed [SAMPLE_BITS-1:0]  b_d;
    logic signed [PROD_W-1:0]       b_prod;
    logic signed [SAMPLE_BITS:0]    b_shift;
    logic signed [SUM_W-1:0]        b_sum;
    logic signed [SAMPLE_BITS-1:0]  b_y;
    logic signed [SAMPLE_BITS-1:0]  b_wr_data;

    // ---- configuration and delay modulo ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FIR;
            r_gain     <= '0;
            r_delay    <= '0;
            r_dl_q     <= '0;
            r_dl_mod   <= '0;
            r_cfg_wait <= '0;
        end else begin
            r_dl_q   <= dl_quo;
            r_dl_mod <= AW'(dl_rem);
            if (i_cfg_wr_en) begin
                r_cfg_wait <= 2'd2;
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[0]);
                    CFG_GAIN:  r_gain  <= $signed(i_cfg_data[GAIN_BITS-1:0]);
                    CFG_DELAY: r_delay <= i_cfg_data[DELAY_BITS-1:0];
                    default: begin
                    end
                endcase
            end else if (r_cfg_wait != 2'd0) begin
                r_cfg_wait <= r_cfg_wait - 2'd1;
            end
        end
    end

    assign dl_prod = DPROD_W'(r_delay) * DPROD_W'(DLY_RECIP);
    assign dl_quo  = DELAY_BITS'(dl_prod >> DLY_SH);
    assign dl_qd   = DELAY_BITS'(r_dl_q * DELAY_BITS'(DELAY_DEPTH));
    assign dl_rem  = r_delay - dl_qd;

    // ---- stage A: accept, address, read issue ----
    assign b_fire        = r_b_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = (r_cfg_wait == 2'd0) && (!r_b_valid || b_fire);
    assign a_fire        = s_axis_tvalid && s_axis_tready;

    assign rd_addr = (r_wp >= r_dl_mod) ? (r_wp - r_dl_mod)
                   : AW'((AW+1)'(r_wp) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(r_dl_mod));
    assign n_wp    = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign a_self  = (r_mode == MODE_FIR) && (r_dl_mod == '0);

    fiic_delay_mem #(
        .DEPTH (DELAY_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (a_fire),
        .i_rd_addr (rd_addr),
        .i_wr_en   (b_fire),
        .i_wr_addr (r_b_wp),
        .i_wr_data (b_wr_data),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_fire) begin
                r_wp <= n_wp;
            end
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_x        <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
            r_b_last     <= s_axis_tlast;
            r_b_wp       <= r_wp;
            r_b_self     <= a_self;
            // same-edge write-back to the entry being read
            r_b_fwd      <= b_fire && (rd_addr == r_b_wp);
            r_b_fwd_data <= b_wr_data;
        end
        if (b_fire) begin
            r_o_sample <= b_y;
            r_o_last   <= r_b_last;
        end
    end

    // ---- stage B: multiply-add, saturate, write back ----
    always_comb begin
        if (r_b_self) begin
            b_d = r_b_x;
        end else if (r_b_fwd) begin
            b_d = r_b_fwd_data;
        end else begin
            b_d = $signed(mem_rd_data);
        end
    end

    assign b_prod  = r_gain * b_d;
    assign b_shift = $signed(b_prod[PROD_W-1:FRAC_BITS]);
    assign b_sum   = SUM_W'(b_shift) + SUM_W'(r_b_x);

    always_comb begin
        if ((b_sum[SUM_W-1:SAMPLE_BITS-1] == '0) || (b_sum[SUM_W-1:SAMPLE_BITS-1] == '1)) begin
            b_y = b_sum[SAMPLE_BITS-1:0];
        end else if (b_sum[SUM_W-1]) begin
            b_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            b_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign b_wr_data = (r_mode == MODE_IIR) ? b_y : r_b_x;

    // ---- output ----
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = TDATA_W'(r_o_sample);
    assign m_axis_tlast  = r_o_last;

    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg_wait != 2'd0 |-> !s_axis_tready)
        else $error("request taken before delay modulo settled");

    a_stage_b_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_fire && r_b_valid |-> b_fire)
        else $error("stage B overwritten");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire |=> r_o_valid)
        else $error("result lost between stage B and output");

endmodule
